// ===== design/cmyk_ordered_dither_column_mark_defines.svh =====
// assertion macros shared by the column mark checker
`ifndef CMYK_ORDERED_DITHER_COLUMN_MARK_DEFINES_SVH
`define CMYK_ORDERED_DITHER_COLUMN_MARK_DEFINES_SVH

// implication checked on the same clock edge
`define COD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the following clock edge
`define COD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cod_pkg.sv =====
// shared types and constants of the cmyk column mark block
package cod_pkg;

  // fixed geometry
  localparam int MAX_COLUMNS   = 4096;
  localparam int MAX_REPLICATE = 16;
  localparam int COL_W         = $clog2(MAX_COLUMNS);
  localparam int CNT_W         = 5;
  localparam int LEVEL_W       = 8;
  localparam int ROW_W         = 16;
  localparam int THR_W         = 4;

  // stream and config port widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_144  = 3'd6;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } cod_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } cod_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last;
  } cod_sts_t;

endpackage

// ===== design/cod_ctrl.sv =====
// controller state machine: item accept, column sequencing, output valid
module cod_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  cod_pkg::cod_sts_t sts_i,
  output cod_pkg::cod_cmd_t cmd_o
);
  import cod_pkg::*;

  cod_state_e state_q, state_d;
  logic       out_vld_q, out_vld_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        // one column per cycle while the output register can take it
        if (!out_vld_q || m_ready_i) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.emit) begin
      out_vld_d = 1'b1;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign m_valid_o = out_vld_q;

endmodule

// ===== design/cod_dp.sv =====
// datapath: config registers, pixel hold, column counter, dot compare, output register
module cod_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cod_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cod_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              row_start_i,
  input  logic [cod_pkg::LEVEL_W-1:0]       black_level_i,
  input  logic [cod_pkg::LEVEL_W-1:0]       yellow_level_i,
  input  logic [cod_pkg::LEVEL_W-1:0]       magenta_level_i,
  input  logic [cod_pkg::LEVEL_W-1:0]       cyan_level_i,
  input  logic [cod_pkg::CNT_W-1:0]         replicate_count_i,
  input  cod_pkg::cod_cmd_t                 cmd_i,
  output cod_pkg::cod_sts_t                 sts_o,
  output logic [cod_pkg::COL_W-1:0]         column_o,
  output logic [2:0]                        bit_index_o,
  output logic                              buffer_half_o,
  output logic                              black_dot_o,
  output logic                              yellow_dot_o,
  output logic                              magenta_dot_o,
  output logic                              cyan_dot_o,
  output logic                              last_of_pixel_o
);
  import cod_pkg::*;

  localparam logic [CNT_W-1:0] MaxRep = CNT_W'(MAX_REPLICATE);

  // configuration registers
  logic [THR_W-1:0]      thr_q;
  logic                  colour_q;
  logic [CFG_DATA_W-1:0] dith_lo_q, dith_hi_q;
  logic [ROW_W-1:0]      row_q;
  logic [COL_W-1:0]      start_col_q;
  logic                  vert_q;

  // per-item state
  logic [COL_W-1:0]   col_q, col_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEVEL_W-1:0] blk_q, yel_q, mag_q, cyn_q;

  // dot decision signals
  logic [ROW_W-1:0]     eff_row;
  logic [3:0]           mat_idx;
  logic [2*CFG_DATA_W-1:0] mat_bits;
  logic [LEVEL_W-1:0]   mat_val;
  logic [CNT_W-1:0]     n_clamp;
  logic                 bd, yd, md, cd;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      colour_q    <= 1'b0;
      dith_lo_q   <= '0;
      dith_hi_q   <= '0;
      row_q       <= '0;
      start_col_q <= '0;
      vert_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: thr_q       <= cfg_data_i[THR_W-1:0];
        CFG_COLOUR:    colour_q    <= cfg_data_i[0];
        CFG_DITHER_LO: dith_lo_q   <= cfg_data_i;
        CFG_DITHER_HI: dith_hi_q   <= cfg_data_i;
        CFG_ROW:       row_q       <= cfg_data_i[ROW_W-1:0];
        CFG_START_COL: start_col_q <= cfg_data_i[COL_W-1:0];
        CFG_VERT_144:  vert_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // replicate count: zero means one, saturate at the maximum
  always_comb begin
    n_clamp = replicate_count_i;
    if (replicate_count_i == '0) begin
      n_clamp = CNT_W'(1);
    end else if (replicate_count_i > MaxRep) begin
      n_clamp = MaxRep;
    end
  end

  // column counter and remaining count
  always_comb begin
    col_d = col_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      if (row_start_i) begin
        col_d = start_col_q;
      end
      cnt_d = n_clamp;
    end else if (cmd_i.emit) begin
      col_d = col_q + COL_W'(1);
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      cnt_q <= '0;
    end else begin
      col_q <= col_d;
      cnt_q <= cnt_d;
    end
  end

  // pixel levels held for the whole run
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      blk_q <= black_level_i;
      yel_q <= yellow_level_i;
      mag_q <= magenta_level_i;
      cyn_q <= cyan_level_i;
    end
  end

  assign sts_o.last = (cnt_q == CNT_W'(1));

  // effective row and matrix entry
  assign eff_row  = vert_q ? (row_q >> 1) : row_q;
  assign mat_idx  = {eff_row[1:0], col_q[1:0]};
  assign mat_bits = {dith_hi_q, dith_lo_q};
  assign mat_val  = mat_bits[{mat_idx, 3'b000} +: LEVEL_W];

  // dot decisions: threshold, greyscale dither, colour with black replacement
  always_comb begin
    bd = 1'b0;
    yd = 1'b0;
    md = 1'b0;
    cd = 1'b0;
    if (thr_q != '0) begin
      bd = (blk_q > {{(LEVEL_W-THR_W){1'b0}}, thr_q ^ {THR_W{1'b1}}});
    end else if (blk_q > mat_val) begin
      bd = 1'b1;
    end else if (colour_q) begin
      yd = (yel_q > mat_val);
      md = (mag_q > mat_val);
      cd = (cyn_q > mat_val);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      column_o        <= col_q;
      bit_index_o     <= eff_row[2:0];
      buffer_half_o   <= vert_q & row_q[0];
      black_dot_o     <= bd;
      yellow_dot_o    <= yd;
      magenta_dot_o   <= md;
      cyan_dot_o      <= cd;
      last_of_pixel_o <= sts_o.last;
    end
  end

endmodule

// ===== design/cmyk_ordered_dither_column_mark.sv =====
// An accepted input item is loaded into the pixel hold and counter registers, then its first
// result item into the output register. It yields n result items, n = effective replicate count
// (1 to 16), and no new item is taken until the last is emitted. The single compare datapath
// produces one printer column per cycle, stalled by the output register while tready is low.
// Reset (async, active low) clears all config registers, the column counter
// and the controller; output payload is not reset.
module cmyk_ordered_dither_column_mark (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [cod_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cod_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // pixel input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] black_level, [15:8] yellow_level, [23:16] magenta_level,
  // [31:24] cyan_level, [36:32] replicate_count, [39:37] zero
  input  logic [cod_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // [0] row_start
  input  logic                                s_axis_tuser_i,
  // mark output stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [11:0] column, [14:12] bit_index, [15] buffer_half, [16] black_dot,
  // [17] yellow_dot, [18] magenta_dot, [19] cyan_dot, [23:20] zero
  output logic [cod_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // last_of_pixel
  output logic                                m_axis_tlast_o
);
  import cod_pkg::*;

  cod_cmd_t         cmd;
  cod_sts_t         sts;
  logic [COL_W-1:0] column;
  logic [2:0]       bit_index;
  logic             buffer_half;
  logic             black_dot, yellow_dot, magenta_dot, cyan_dot;

  // controller
  cod_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath
  cod_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .row_start_i       (s_axis_tuser_i),
    .black_level_i     (s_axis_tdata_i[7:0]),
    .yellow_level_i    (s_axis_tdata_i[15:8]),
    .magenta_level_i   (s_axis_tdata_i[23:16]),
    .cyan_level_i      (s_axis_tdata_i[31:24]),
    .replicate_count_i (s_axis_tdata_i[36:32]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .column_o          (column),
    .bit_index_o       (bit_index),
    .buffer_half_o     (buffer_half),
    .black_dot_o       (black_dot),
    .yellow_dot_o      (yellow_dot),
    .magenta_dot_o     (magenta_dot),
    .cyan_dot_o        (cyan_dot),
    .last_of_pixel_o   (m_axis_tlast_o)
  );

  // output packing
  assign m_axis_tdata_o = {4'b0000, cyan_dot, magenta_dot, yellow_dot, black_dot,
                           buffer_half, bit_index, column};

endmodule

// ===== design/cod_chk.sv =====
// port-level checker for the cmyk column mark block, bound to the top level
`include "cmyk_ordered_dither_column_mark_defines.svh"

module cod_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [cod_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tlast_o
);
  import cod_pkg::*;

  logic             in_take;
  logic             out_wait;
  logic             mid_pix;
  logic             mid_take;
  logic [COL_W-1:0] out_col;
  logic [COL_W-1:0] col_inc_q;

  // handshake and column views of the ports
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_wait = m_axis_tvalid_o && !m_axis_tready_i;
  assign mid_pix  = m_axis_tvalid_o && !m_axis_tlast_o;
  assign mid_take = mid_pix && m_axis_tready_i;
  assign out_col  = m_axis_tdata_o[COL_W-1:0];

  // column that the next item of the same pixel must carry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_inc_q <= '0;
    end else begin
      col_inc_q <= out_col + COL_W'(1);
    end
  end

  // a waiting result item is not withdrawn
  `COD_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid_o, "result item dropped while stalled")

  // no new pixel is taken while a non-final column of the current one waits
  `COD_ASSERT_NOW(a_no_accept_mid, mid_pix, !s_axis_tready_o, "input ready mid pixel")

  // one pixel at a time
  `COD_ASSERT_NEXT(a_busy_after_accept, in_take, !s_axis_tready_o, "input ready after accept")

  // replicated columns of one pixel follow back to back with the column advancing by one
  `COD_ASSERT_NEXT(a_col_step, mid_take, m_axis_tvalid_o && out_col == col_inc_q, "column skip")

endmodule

bind cmyk_ordered_dither_column_mark cod_chk u_cod_chk (.*);

// ===== sim/tb.sv =====
// testbench of the cmyk ordered dither column mark block: scoreboard, drivers and stimulus
`timescale 1ns / 1ps

module tb;
  import cod_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX  = 10;

  // one printer column mark
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [2:0]       bit_index;
    logic             half;
    logic             black;
    logic             yellow;
    logic             magenta;
    logic             cyan;
    logic             last;
  } mark_t;

  // column mark predictor and queue of marks still due from the block
  class mark_board;
    logic [THR_W-1:0] thr_level   = '0;
    logic             colour_on   = 1'b0;
    logic [63:0]      matrix_lo   = '0;
    logic [63:0]      matrix_hi   = '0;
    logic [ROW_W-1:0] row_num     = '0;
    logic [COL_W-1:0] first_col   = '0;
    logic             dpi_144     = 1'b0;
    logic [COL_W-1:0] cur_col     = '0;
    mark_t            due_marks[$];
    int               fails       = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THRESHOLD: thr_level = data[THR_W-1:0];
        CFG_COLOUR:    colour_on = data[0];
        CFG_DITHER_LO: matrix_lo = data;
        CFG_DITHER_HI: matrix_hi = data;
        CFG_ROW:       row_num   = data[ROW_W-1:0];
        CFG_START_COL: first_col = data[COL_W-1:0];
        CFG_VERT_144:  dpi_144   = data[0];
        default: ;
      endcase
    endfunction

    // predict the marks of one accepted pixel
    function void note_pixel(logic rs, logic [7:0] k, logic [7:0] y, logic [7:0] m,
                             logic [7:0] c, logic [CNT_W-1:0] cnt);
      int unsigned      reps;
      logic [ROW_W-1:0] eff_row;
      logic             half_sel;
      logic [3:0]       entry;
      logic [7:0]       level;
      mark_t            mk;
      if (rs) cur_col = first_col;
      if (cnt == 0) reps = 1;
      else if (cnt > MAX_REPLICATE) reps = MAX_REPLICATE;
      else reps = cnt;
      eff_row  = dpi_144 ? (row_num >> 1) : row_num;
      half_sel = dpi_144 ? row_num[0] : 1'b0;
      for (int i = 0; i < reps; i++) begin
        mk           = '0;
        mk.column    = cur_col;
        mk.bit_index = eff_row[2:0];
        mk.half      = half_sel;
        entry        = {eff_row[1:0], cur_col[1:0]};
        level        = entry[3] ? matrix_hi[entry[2:0]*8 +: 8] : matrix_lo[entry[2:0]*8 +: 8];
        if (thr_level != 0) begin
          mk.black = (k > {4'h0, thr_level ^ 4'hF});
        end else if (k > level) begin
          mk.black = 1'b1;
        end else if (colour_on) begin
          mk.yellow  = (y > level);
          mk.magenta = (m > level);
          mk.cyan    = (c > level);
        end
        mk.last = (i == reps - 1);
        due_marks.push_back(mk);
        cur_col = cur_col + 1'b1;
      end
    endfunction

    // compare one accepted mark with the oldest prediction
    function void check_mark(logic [OUT_DATA_W-1:0] data, logic last);
      mark_t got;
      mark_t want;
      got.column    = data[11:0];
      got.bit_index = data[14:12];
      got.half      = data[15];
      got.black     = data[16];
      got.yellow    = data[17];
      got.magenta   = data[18];
      got.cyan      = data[19];
      got.last      = last;
      if (due_marks.size() == 0) begin
        if (fails < REPORT_MAX)
          $display("tb: unexpected mark col=%0d bit=%0d half=%0d kymc=%b%b%b%b last=%0b",
                   got.column, got.bit_index, got.half, got.black, got.yellow,
                   got.magenta, got.cyan, got.last);
        fails++;
        return;
      end
      want = due_marks.pop_front();
      if (got.column != want.column || got.bit_index != want.bit_index ||
          got.half != want.half || got.black != want.black || got.yellow != want.yellow ||
          got.magenta != want.magenta || got.cyan != want.cyan || got.last != want.last) begin
        if (fails < REPORT_MAX) begin
          $write("tb: mark mismatch exp col=%0d bit=%0d half=%0d kymc=%b%b%b%b last=%0b",
                 want.column, want.bit_index, want.half, want.black, want.yellow,
                 want.magenta, want.cyan, want.last);
          $display(" got col=%0d bit=%0d half=%0d kymc=%b%b%b%b last=%0b",
                   got.column, got.bit_index, got.half, got.black, got.yellow,
                   got.magenta, got.cyan, got.last);
        end
        fails++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_valid;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data;
  logic                  s_user;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  m_last;

  int        send_idle_pct = 22;
  int        recv_idle_pct = 75;
  int        cycles        = 0;
  mark_board board;

  cmyk_ordered_dither_column_mark i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),  // [7:0] black, [15:8] yellow, [23:16] magenta, [31:24] cyan,
                                // [36:32] replicate_count
    .s_axis_tuser_i  (s_user),  // [0] row_start
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),  // [11:0] column, [14:12] bit_index, [15] buffer_half,
                                // [16] black, [17] yellow, [18] magenta, [19] cyan
    .m_axis_tlast_o  (m_last)
  );

  always #1 clk_i = ~clk_i;

  // receiver stalls, changed on the falling edge
  always @(negedge clk_i) begin
    m_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // accepted marks and run limit
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && m_valid && m_ready) board.check_mark(m_data, m_last);
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we   = 1'b0;
    board.write_reg(idx, data);
  endtask

  // wait until every predicted mark has come out and the block is idle
  task automatic drain();
    while (board.due_marks.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // offer one pixel item, called and returning at the falling edge
  task automatic send_pixel(logic rs, logic [7:0] k, logic [7:0] y, logic [7:0] m,
                            logic [7:0] c, logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_user  = rs;
    s_data  = {3'b000, cnt, c, m, y, k};
    do @(posedge clk_i); while (!s_ready);
    board.note_pixel(rs, k, y, m, c, cnt);
    @(negedge clk_i);
    s_valid = 1'b0;
  endtask

  // fresh settings for one random phase, extremes included
  task automatic random_setup();
    logic [63:0] word;
    case ($urandom_range(3))
      0, 1:    cfg_write(CFG_THRESHOLD, 64'd0);
      2:       cfg_write(CFG_THRESHOLD, 64'($urandom_range(1, 15)));
      default: cfg_write(CFG_THRESHOLD, $urandom_range(1) ? 64'd15 : 64'd1);
    endcase
    cfg_write(CFG_COLOUR, 64'($urandom_range(1)));
    for (int j = 0; j < 2; j++) begin
      case ($urandom_range(5))
        0:       word = '0;
        1:       word = '1;
        default: word = {$urandom, $urandom};
      endcase
      cfg_write(j == 0 ? CFG_DITHER_LO : CFG_DITHER_HI, word);
    end
    case ($urandom_range(4))
      0:       cfg_write(CFG_ROW, 64'hFFFF);
      1:       cfg_write(CFG_ROW, 64'h0);
      default: cfg_write(CFG_ROW, 64'($urandom_range(16'hFFFF)));
    endcase
    if ($urandom_range(2) == 0) cfg_write(CFG_START_COL, 64'($urandom_range(4080, 4095)));
    else cfg_write(CFG_START_COL, 64'($urandom_range(4095)));
    cfg_write(CFG_VERT_144, 64'($urandom_range(1)));
  endtask

  initial begin
    logic [CNT_W-1:0] cnt;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    s_valid  = 1'b0;
    s_data   = '0;
    s_user   = 1'b0;
    board    = new;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: all-zero matrix, greyscale, zero and oversized replication
    send_pixel(1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 5'd0);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd16);
    send_pixel(1'b0, 8'h01, 8'hFF, 8'h00, 8'hFF, 5'd31);
    drain();

    // colour dither with a graded matrix, column wrap at the right edge
    cfg_write(CFG_COLOUR, 64'd1);
    cfg_write(CFG_DITHER_LO, 64'h7060504030201000);
    cfg_write(CFG_DITHER_HI, 64'hF0E0D0C0B0A09080);
    cfg_write(CFG_ROW, 64'd5);
    cfg_write(CFG_START_COL, 64'd4094);
    send_pixel(1'b1, 8'h50, 8'hFF, 8'h00, 8'h80, 5'd5);
    send_pixel(1'b0, 8'h00, 8'h10, 8'h11, 8'hFF, 5'd8);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd2);
    drain();

    // saturated matrix: nothing can exceed it
    cfg_write(CFG_DITHER_LO, '1);
    cfg_write(CFG_DITHER_HI, '1);
    send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd4);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 5'd17);
    drain();

    // threshold mode at both ends, colour fields forced off
    cfg_write(CFG_THRESHOLD, 64'd15);
    send_pixel(1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 5'd1);
    send_pixel(1'b0, 8'h01, 8'hFF, 8'hFF, 8'hFF, 5'd3);
    drain();
    cfg_write(CFG_THRESHOLD, 64'd1);
    send_pixel(1'b0, 8'h0E, 8'hFF, 8'hFF, 8'hFF, 5'd2);
    send_pixel(1'b0, 8'h0F, 8'h00, 8'h00, 8'h00, 5'd2);
    send_pixel(1'b0, 8'hFF, 8'hAA, 8'h55, 8'hAA, 5'd1);
    drain();

    // 144 dpi interleave, odd and even rows, last column
    cfg_write(CFG_THRESHOLD, 64'd0);
    cfg_write(CFG_DITHER_LO, 64'h0F0E0D0C0B0A0908);
    cfg_write(CFG_DITHER_HI, 64'h8070605040302010);
    cfg_write(CFG_VERT_144, 64'd1);
    cfg_write(CFG_ROW, 64'hFFFF);
    cfg_write(CFG_START_COL, 64'd4095);
    send_pixel(1'b1, 8'h0C, 8'h90, 8'h30, 8'h00, 5'd16);
    drain();
    cfg_write(CFG_ROW, 64'd6);
    send_pixel(1'b1, 8'h00, 8'h40, 8'h80, 8'hC0, 5'd6);
    drain();

    // random phases: rows of random pixels under random settings
    for (int p = 0; p < 10; p++) begin
      if (p < 4) begin
        send_idle_pct = 22;
        recv_idle_pct = 75;
      end else if (p < 7) begin
        send_idle_pct = 75;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setup();
      for (int i = 0; i < 10; i++) begin
        if ($urandom_range(9) == 0) cnt = CNT_W'($urandom_range(17, 31));
        else cnt = CNT_W'($urandom_range(0, 16));
        send_pixel((i == 0) || ($urandom_range(7) == 0), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), cnt);
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (board.fails == 0 && board.due_marks.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
